### src/v3alu_pkg.sv
`default_nettype none

package v3alu_pkg;

    // widths
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = WORD_W + FRAC_W;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int WIDE_W    = PROD_W + 4;
    localparam int REM_W     = WORD_W + 2;
    localparam int SQ_STEPS  = 4;
    localparam int SQ_STAGES = WORD_W / SQ_STEPS;
    localparam int DV_STEPS  = 4;
    localparam int DV_STAGES = NUM_W / DV_STEPS;
    localparam int N_MUL     = 6;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_HADAMARD  = 4'd2,
        OP_SCALE     = 4'd3,
        OP_DIVIDE    = 4'd4,
        OP_DOT       = 4'd5,
        OP_CROSS     = 4'd6,
        OP_NORMALIZE = 4'd7,
        OP_NEGATE    = 4'd8,
        OP_NORMSQ    = 4'd9,
        OP_NORM      = 4'd10,
        OP_EQUAL     = 4'd11
    } op_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } stat_t;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [3:0]               func;
        logic signed [WORD_W-1:0] a_x;
        logic signed [WORD_W-1:0] a_y;
        logic signed [WORD_W-1:0] a_z;
        logic signed [WORD_W-1:0] b_x;
        logic signed [WORD_W-1:0] b_y;
        logic signed [WORD_W-1:0] b_z;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] r_x;
        logic signed [WORD_W-1:0] r_y;
        logic signed [WORD_W-1:0] r_z;
        logic signed [WORD_W-1:0] scalar_out;
        logic                     equal_flag;
        logic [1:0]               status;
    } out_word_t;

    typedef struct packed {
        logic  ovf;
        word_t val;
    } sat_t;

    // products stage
    typedef struct packed {
        logic [3:0]                   func;
        logic [N_MUL-1:0][PROD_W-1:0] prod;
        logic [2:0][WORD_W:0]         as;
        logic                         eq;
        logic [2:0][WORD_W-1:0]       a;
        word_t                        bx;
    } s2_t;

    // results and control carried down the pipe
    typedef struct packed {
        logic [3:0]             func;
        logic [2:0][WORD_W-1:0] rv;
        word_t                  sc;
        logic                   eq;
        logic [1:0]             st;
        logic [2:0]             neg;
        logic                   zero;
        logic [2:0][WORD_W-1:0] amag;
        word_t                  bmag;
        word_t                  root;
    } side_t;

    typedef struct packed {
        logic [PROD_W-1:0] rad;
        logic [REM_W-1:0]  rem;
        word_t             root;
    } sq_t;

    typedef struct packed {
        side_t side;
        sq_t   sq;
    } sq_stage_t;

    typedef struct packed {
        logic [NUM_W-1:0] nq;
        word_t            rem;
    } dv_t;

    typedef struct packed {
        side_t      side;
        word_t      dsr;
        dv_t [2:0]  lane;
    } dv_stage_t;

    // saturate a wide signed value to one word
    function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        sat_t r;
        hi = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = {{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
        if (v > hi)
        begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            r.ovf = 1'b1;
            r.val = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // signed quotient magnitude to saturated word
    function automatic sat_t sat_quot(input logic [NUM_W-1:0] q, input logic neg);
        logic [NUM_W-1:0] lim;
        sat_t r;
        lim = {{(NUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        r.ovf = 1'b0;
        if (!neg)
        begin
            if (q > lim)
            begin
                r.ovf = 1'b1;
                r.val = {1'b0, {(WORD_W-1){1'b1}}};
            end
            else
            begin
                r.val = q[WORD_W-1:0];
            end
        end
        else
        begin
            if (q > lim + 1'b1)
            begin
                r.ovf = 1'b1;
                r.val = {1'b1, {(WORD_W-1){1'b0}}};
            end
            else
            begin
                r.val = ~q[WORD_W-1:0] + 1'b1;
            end
        end
        return r;
    endfunction

    // magnitude of a two's complement word
    function automatic word_t mag(input word_t v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // restoring square root, two radicand bits per step
    function automatic sq_t sqrt_steps(input sq_t s);
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] trial;
        sq_t t;
        t = s;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            r2    = {t.rem[REM_W-3:0], t.rad[PROD_W-1 -: 2]};
            trial = {t.root, 2'b01};
            if (r2 >= trial)
            begin
                t.rem  = r2 - trial;
                t.root = {t.root[WORD_W-2:0], 1'b1};
            end
            else
            begin
                t.rem  = r2;
                t.root = {t.root[WORD_W-2:0], 1'b0};
            end
            t.rad = {t.rad[PROD_W-3:0], 2'b00};
        end
        return t;
    endfunction

    // restoring division, one quotient bit per step
    function automatic dv_t div_steps(input dv_t s, input word_t d);
        logic [WORD_W:0] r2;
        logic            qb;
        dv_t t;
        t = s;
        for (int i = 0; i < DV_STEPS; i++)
        begin
            r2 = {t.rem, t.nq[NUM_W-1]};
            qb = (r2 >= {1'b0, d});
            if (qb)
            begin
                r2 = r2 - {1'b0, d};
            end
            t.rem = r2[WORD_W-1:0];
            t.nq  = {t.nq[NUM_W-2:0], qb};
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### src/vec3_fixed_point_alu.sv
// channel | signals                        | word
// in      | in_valid, in_ready, in_data    | func, a_x..a_z, b_x..b_z
// out     | out_valid, out_ready, out_data | r_x..r_z, scalar_out, equal_flag, status
//
// one word accepted per cycle while out_ready does not hold the pipe; every operation passes
// through the root stage (4 root bits per stage, 8 stages) followed by
// the divide stage (4 quotient bits per stage, 12 stages, three lanes)
// rst_n clears all valid bits at once; data registers are not reset
// the whole pipe holds while a result waits on out_ready, nothing is lost or repeated
`default_nettype none

module vec3_fixed_point_alu
    import v3alu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic      en;
    logic      s1_vld_reg;
    in_word_t  s1_reg;
    logic      s2_vld_reg;
    s2_t       s2_reg;
    s2_t       s2_next;
    logic      s3_vld_reg;
    sq_stage_t s3_reg;
    sq_stage_t s3_next;
    logic      sq_vld_reg [SQ_STAGES];
    sq_stage_t sq_reg     [SQ_STAGES];
    sq_stage_t sq_next    [SQ_STAGES];
    logic      dv_vld_reg [DV_STAGES];
    dv_stage_t dv_reg     [DV_STAGES];
    dv_stage_t dv_next    [DV_STAGES];
    dv_stage_t dv_entry;
    logic      out_vld_reg;
    out_word_t out_reg;
    out_word_t out_next;

    // global advance: hold while the output word is not taken
    assign en        = !out_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // operand select and multipliers
    always_comb
    begin
        logic signed [WORD_W-1:0] opa [N_MUL];
        logic signed [WORD_W-1:0] opb [N_MUL];
        logic signed [PROD_W-1:0] p;
        for (int k = 0; k < N_MUL; k++)
        begin
            opa[k] = '0;
            opb[k] = '0;
        end
        case (s1_reg.func) inside
            OP_HADAMARD, OP_DOT:
            begin
                opa[0] = s1_reg.a_x; opb[0] = s1_reg.b_x;
                opa[1] = s1_reg.a_y; opb[1] = s1_reg.b_y;
                opa[2] = s1_reg.a_z; opb[2] = s1_reg.b_z;
            end
            OP_SCALE:
            begin
                opa[0] = s1_reg.a_x; opb[0] = s1_reg.b_x;
                opa[1] = s1_reg.a_y; opb[1] = s1_reg.b_x;
                opa[2] = s1_reg.a_z; opb[2] = s1_reg.b_x;
            end
            OP_NORMSQ, OP_NORM, OP_NORMALIZE:
            begin
                opa[0] = s1_reg.a_x; opb[0] = s1_reg.a_x;
                opa[1] = s1_reg.a_y; opb[1] = s1_reg.a_y;
                opa[2] = s1_reg.a_z; opb[2] = s1_reg.a_z;
            end
            OP_CROSS:
            begin
                opa[0] = s1_reg.a_y; opb[0] = s1_reg.b_z;
                opa[3] = s1_reg.a_z; opb[3] = s1_reg.b_y;
                opa[1] = s1_reg.a_z; opb[1] = s1_reg.b_x;
                opa[4] = s1_reg.a_x; opb[4] = s1_reg.b_z;
                opa[2] = s1_reg.a_x; opb[2] = s1_reg.b_y;
                opa[5] = s1_reg.a_y; opb[5] = s1_reg.b_x;
            end
            default:
            begin
            end
        endcase
        s2_next.func = s1_reg.func;
        for (int k = 0; k < N_MUL; k++)
        begin
            p = PROD_W'(opa[k]) * PROD_W'(opb[k]);
            s2_next.prod[k] = p;
        end
        s2_next.a[0] = s1_reg.a_x;
        s2_next.a[1] = s1_reg.a_y;
        s2_next.a[2] = s1_reg.a_z;
        s2_next.bx   = s1_reg.b_x;
        s2_next.eq   = (s1_reg.a_x == s1_reg.b_x) && (s1_reg.a_y == s1_reg.b_y)
                    && (s1_reg.a_z == s1_reg.b_z);
        // add, sub and negate at one extra bit
        for (int i = 0; i < 3; i++)
        begin
            s2_next.as[i] = '0;
        end
        case (s1_reg.func) inside
            OP_ADD:
            begin
                s2_next.as[0] = {s1_reg.a_x[WORD_W-1], s1_reg.a_x}
                              + {s1_reg.b_x[WORD_W-1], s1_reg.b_x};
                s2_next.as[1] = {s1_reg.a_y[WORD_W-1], s1_reg.a_y}
                              + {s1_reg.b_y[WORD_W-1], s1_reg.b_y};
                s2_next.as[2] = {s1_reg.a_z[WORD_W-1], s1_reg.a_z}
                              + {s1_reg.b_z[WORD_W-1], s1_reg.b_z};
            end
            OP_SUB:
            begin
                s2_next.as[0] = {s1_reg.a_x[WORD_W-1], s1_reg.a_x}
                              - {s1_reg.b_x[WORD_W-1], s1_reg.b_x};
                s2_next.as[1] = {s1_reg.a_y[WORD_W-1], s1_reg.a_y}
                              - {s1_reg.b_y[WORD_W-1], s1_reg.b_y};
                s2_next.as[2] = {s1_reg.a_z[WORD_W-1], s1_reg.a_z}
                              - {s1_reg.b_z[WORD_W-1], s1_reg.b_z};
            end
            OP_NEGATE:
            begin
                s2_next.as[0] = (WORD_W+1)'(0) - {s1_reg.a_x[WORD_W-1], s1_reg.a_x};
                s2_next.as[1] = (WORD_W+1)'(0) - {s1_reg.a_y[WORD_W-1], s1_reg.a_y};
                s2_next.as[2] = (WORD_W+1)'(0) - {s1_reg.a_z[WORD_W-1], s1_reg.a_z};
            end
            default:
            begin
            end
        endcase
    end

    // combine products, saturate the simple results, seed the root
    always_comb
    begin
        logic signed [PROD_W:0]   cdiff;
        logic signed [PROD_W+1:0] dsum;
        sat_t                     vs   [3];
        sat_t                     ssat;
        side_t                    sd;
        dsum = $signed({{2{s2_reg.prod[0][PROD_W-1]}}, s2_reg.prod[0]})
             + $signed({{2{s2_reg.prod[1][PROD_W-1]}}, s2_reg.prod[1]})
             + $signed({{2{s2_reg.prod[2][PROD_W-1]}}, s2_reg.prod[2]});
        ssat = sat_wide(WIDE_W'(dsum >>> FRAC_W));
        for (int i = 0; i < 3; i++)
        begin
            cdiff = $signed({s2_reg.prod[i][PROD_W-1], s2_reg.prod[i]})
                  - $signed({s2_reg.prod[i+3][PROD_W-1], s2_reg.prod[i+3]});
            if (s2_reg.func == OP_ADD || s2_reg.func == OP_SUB
                || s2_reg.func == OP_NEGATE)
            begin
                vs[i] = sat_wide(WIDE_W'($signed(s2_reg.as[i])));
            end
            else
            begin
                vs[i] = sat_wide(WIDE_W'(cdiff >>> FRAC_W));
            end
        end
        sd.func = s2_reg.func;
        sd.rv   = '0;
        sd.sc   = '0;
        sd.eq   = 1'b0;
        sd.st   = ST_OK;
        sd.root = '0;
        sd.bmag = mag(s2_reg.bx);
        for (int i = 0; i < 3; i++)
        begin
            sd.amag[i] = mag(s2_reg.a[i]);
            sd.neg[i]  = s2_reg.a[i][WORD_W-1]
                       ^ ((s2_reg.func == OP_DIVIDE) & s2_reg.bx[WORD_W-1]);
        end
        sd.zero = (s2_reg.func == OP_DIVIDE) ? (s2_reg.bx == '0) : (dsum == '0);
        case (s2_reg.func) inside
            OP_ADD, OP_SUB, OP_NEGATE, OP_HADAMARD, OP_SCALE, OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sd.rv[i] = vs[i].val;
                end
                sd.st = (vs[0].ovf || vs[1].ovf || vs[2].ovf) ? ST_SAT : ST_OK;
            end
            OP_DOT, OP_NORMSQ:
            begin
                sd.sc = ssat.val;
                sd.st = ssat.ovf ? ST_SAT : ST_OK;
            end
            OP_EQUAL:
            begin
                sd.eq = s2_reg.eq;
            end
            default:
            begin
            end
        endcase
        s3_next.side    = sd;
        s3_next.sq.rad  = dsum[PROD_W-1:0];
        s3_next.sq.rem  = '0;
        s3_next.sq.root = '0;
    end

    // square root stages
    always_comb
    begin
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            if (k == 0)
            begin
                sq_next[k].side = s3_reg.side;
                sq_next[k].sq   = sqrt_steps(s3_reg.sq);
            end
            else
            begin
                sq_next[k].side = sq_reg[k-1].side;
                sq_next[k].sq   = sqrt_steps(sq_reg[k-1].sq);
            end
        end
    end

    // divider seed: divisor is the length for normalize, |b_x| for divide
    always_comb
    begin
        dv_entry.side      = sq_reg[SQ_STAGES-1].side;
        dv_entry.side.root = sq_reg[SQ_STAGES-1].sq.root;
        dv_entry.dsr       = (sq_reg[SQ_STAGES-1].side.func == OP_NORMALIZE)
                           ? sq_reg[SQ_STAGES-1].sq.root
                           : sq_reg[SQ_STAGES-1].side.bmag;
        for (int i = 0; i < 3; i++)
        begin
            dv_entry.lane[i].nq  = {sq_reg[SQ_STAGES-1].side.amag[i], {FRAC_W{1'b0}}};
            dv_entry.lane[i].rem = '0;
        end
    end

    // divide stages, three lanes
    always_comb
    begin
        for (int k = 0; k < DV_STAGES; k++)
        begin
            if (k == 0)
            begin
                dv_next[k].side = dv_entry.side;
                dv_next[k].dsr  = dv_entry.dsr;
                for (int i = 0; i < 3; i++)
                begin
                    dv_next[k].lane[i] = div_steps(dv_entry.lane[i], dv_entry.dsr);
                end
            end
            else
            begin
                dv_next[k].side = dv_reg[k-1].side;
                dv_next[k].dsr  = dv_reg[k-1].dsr;
                for (int i = 0; i < 3; i++)
                begin
                    dv_next[k].lane[i] = div_steps(dv_reg[k-1].lane[i], dv_reg[k-1].dsr);
                end
            end
        end
    end

    // final result word
    always_comb
    begin
        side_t sd;
        sat_t  qs [3];
        sat_t  ns;
        sd = dv_reg[DV_STAGES-1].side;
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = sat_quot(dv_reg[DV_STAGES-1].lane[i].nq, sd.neg[i]);
        end
        ns.ovf = sd.root[WORD_W-1];
        ns.val = sd.root[WORD_W-1] ? {1'b0, {(WORD_W-1){1'b1}}} : sd.root;
        out_next.r_x        = sd.rv[0];
        out_next.r_y        = sd.rv[1];
        out_next.r_z        = sd.rv[2];
        out_next.scalar_out = sd.sc;
        out_next.equal_flag = sd.eq;
        out_next.status     = sd.st;
        case (sd.func) inside
            OP_DIVIDE, OP_NORMALIZE:
            begin
                if (sd.zero)
                begin
                    out_next.r_x    = '0;
                    out_next.r_y    = '0;
                    out_next.r_z    = '0;
                    out_next.status = ST_ZERO;
                end
                else
                begin
                    out_next.r_x    = qs[0].val;
                    out_next.r_y    = qs[1].val;
                    out_next.r_z    = qs[2].val;
                    out_next.status = (qs[0].ovf || qs[1].ovf || qs[2].ovf) ? ST_SAT : ST_OK;
                end
            end
            OP_NORM:
            begin
                out_next.scalar_out = ns.val;
                out_next.status     = ns.ovf ? ST_SAT : ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DV_STAGES; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_vld_reg[k] <= (k == 0) ? s3_vld_reg : sq_vld_reg[(k == 0) ? 0 : k-1];
            end
            for (int k = 0; k < DV_STAGES; k++)
            begin
                dv_vld_reg[k] <= (k == 0) ? sq_vld_reg[SQ_STAGES-1]
                                          : dv_vld_reg[(k == 0) ? 0 : k-1];
            end
            out_vld_reg <= dv_vld_reg[DV_STAGES-1];
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= in_data;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k < DV_STAGES; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            out_reg <= out_next;
        end
    end

    // zero status always comes with a zero vector
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.status == ST_ZERO
        |-> out_reg.r_x == '0 && out_reg.r_y == '0 && out_reg.r_z == '0)
        else $error("zero status with nonzero vector");

    // equality result carries nothing else
    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.equal_flag
        |-> out_reg.status == ST_OK && out_reg.scalar_out == '0 && out_reg.r_x == '0)
        else $error("equal flag with other results");

    // status code three is never produced
    a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_reg.status != 2'd3)
        else $error("bad status code");

endmodule

`default_nettype wire
